// File: design/cas_pkg.sv
// Shared constants and types for the cave automaton step block.
// Standalone package: depends on nothing else in the project.
`default_nettype none

package cas_pkg;

   // Largest frame that the line store and the counters can hold
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int WIDTH_CAP  = (MAX_WIDTH  < 256) ? MAX_WIDTH  : 256;
   localparam int HEIGHT_CAP = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;

   // Line store: one entry per column, two bits (older row, previous row)
   localparam int LINE_ADDR_W = $clog2(MAX_WIDTH);
   localparam int LINE_DATA_W = 2;

   // Field widths
   localparam int DIM_W   = 9;
   localparam int LIMIT_W = 4;
   localparam int COORD_W = 8;
   localparam int COUNT_W = 4;

   // Configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [DIM_W-1:0]   GRID_WIDTH_RST  = 9'd64;
   localparam logic [DIM_W-1:0]   GRID_HEIGHT_RST = 9'd64;
   localparam logic [LIMIT_W-1:0] DEATH_LIMIT_RST = 4'd2;
   localparam logic [LIMIT_W-1:0] BIRTH_LIMIT_RST = 4'd3;

   // Result queue
   localparam int MAX_RESULTS = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   typedef enum logic [1:0] {
      CSR_GRID_WIDTH  = 2'd0,
      CSR_GRID_HEIGHT = 2'd1,
      CSR_DEATH_LIMIT = 2'd2,
      CSR_BIRTH_LIMIT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic               live;
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
      logic               last;
   } result_type;

endpackage

`default_nettype wire

// File: design/cas_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; used for the line store of the cave automaton step.
`default_nettype none

module cas_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: design/cave_automaton_step.sv
// Top level of the cave automaton step: one generation over a raster cell stream.
// Depends on cas_pkg (constants, types) and cas_ram (line store).
`default_nettype none

// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  req_cell_in
// rsp_      out        rsp_valid / rsp_ready  rsp_cell_out, rsp_out_column, rsp_out_row,
//                                             rsp_last_of_frame
// csr_      in/out     APB psel/penable       paddr, pwdata, prdata, pready
//
// Cycles: one cell is taken per cycle while the queue has room; its 0 to 3 results
// are worked out in the cycle of the transaction and land in a four-entry result
// queue, which drains one result per cycle from the cycle after. A row end (two
// results) and the last row (one to three results per cell) can hold req_ready
// low, so the output port sets the long-run rate. The line store is read ahead,
// addressed with the column of the next cell.
// Reset: synchronous; clears counters, window, queue and configuration.
// Stalls: a stalled rsp_ready fills the queue and then drops req_ready.

module cave_automaton_step (
   input  logic                           clock,
   input  logic                           reset,
   // input channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_cell_in,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_cell_out,
   output logic [cas_pkg::COORD_W-1:0]    rsp_out_column,
   output logic [cas_pkg::COORD_W-1:0]    rsp_out_row,
   output logic                           rsp_last_of_frame,
   // configuration port
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [cas_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [cas_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [cas_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [cas_pkg::DIM_W-1:0]   grid_width_ff;
   logic [cas_pkg::DIM_W-1:0]   grid_height_ff;
   logic [cas_pkg::LIMIT_W-1:0] death_limit_ff;
   logic [cas_pkg::LIMIT_W-1:0] birth_limit_ff;

   logic                   csr_write;
   logic                   geometry_write;
   cas_pkg::csr_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = cas_pkg::csr_index_type'(csr_paddr[3:2]);
   // a write to either dimension restarts the frame
   assign geometry_write = csr_write && ((csr_index == cas_pkg::CSR_GRID_WIDTH) ||
                                         (csr_index == cas_pkg::CSR_GRID_HEIGHT));

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= cas_pkg::GRID_WIDTH_RST;
         grid_height_ff <= cas_pkg::GRID_HEIGHT_RST;
         death_limit_ff <= cas_pkg::DEATH_LIMIT_RST;
         birth_limit_ff <= cas_pkg::BIRTH_LIMIT_RST;
      end else if (csr_write) begin
         case (csr_index)
            cas_pkg::CSR_GRID_WIDTH:  grid_width_ff  <= csr_pwdata[cas_pkg::DIM_W-1:0];
            cas_pkg::CSR_GRID_HEIGHT: grid_height_ff <= csr_pwdata[cas_pkg::DIM_W-1:0];
            cas_pkg::CSR_DEATH_LIMIT: death_limit_ff <= csr_pwdata[cas_pkg::LIMIT_W-1:0];
            cas_pkg::CSR_BIRTH_LIMIT: birth_limit_ff <= csr_pwdata[cas_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         cas_pkg::CSR_GRID_WIDTH:  csr_prdata = cas_pkg::CSR_DATA_W'(grid_width_ff);
         cas_pkg::CSR_GRID_HEIGHT: csr_prdata = cas_pkg::CSR_DATA_W'(grid_height_ff);
         cas_pkg::CSR_DEATH_LIMIT: csr_prdata = cas_pkg::CSR_DATA_W'(death_limit_ff);
         cas_pkg::CSR_BIRTH_LIMIT: csr_prdata = cas_pkg::CSR_DATA_W'(birth_limit_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   // Last column and last row in use: dimensions clamped to [3, cap]
   logic [cas_pkg::COORD_W-1:0] width_last;
   logic [cas_pkg::COORD_W-1:0] height_last;

   always_comb begin
      if (grid_width_ff < 9'd3) begin
         width_last = 8'd2;
      end else if (grid_width_ff > 9'(cas_pkg::WIDTH_CAP)) begin
         width_last = 8'(cas_pkg::WIDTH_CAP - 1);
      end else begin
         width_last = 8'(grid_width_ff - 9'd1);
      end
      if (grid_height_ff < 9'd3) begin
         height_last = 8'd2;
      end else if (grid_height_ff > 9'(cas_pkg::HEIGHT_CAP)) begin
         height_last = 8'(cas_pkg::HEIGHT_CAP - 1);
      end else begin
         height_last = 8'(grid_height_ff - 9'd1);
      end
   end

   // ---------------------------------------------------------------
   // Position counters, 3x3 window and line store
   // ---------------------------------------------------------------
   logic [cas_pkg::COORD_W-1:0]     col_ff, col_in;
   logic [cas_pkg::COORD_W-1:0]     row_ff, row_in;
   logic [5:0]                      window_ff, window_in;
   logic [cas_pkg::LINE_DATA_W-1:0] line_rd;
   logic [2:0]                      column_bits;
   logic                            accept;
   logic                            at_row_end;
   logic                            at_last_row;

   assign accept      = req_valid && req_ready;
   assign at_row_end  = (col_ff == width_last);
   assign at_last_row = (row_ff == height_last);
   // bit 0: row r-2, bit 1: row r-1, bit 2: current row
   assign column_bits = {req_cell_in, line_rd[1], line_rd[0]};
   assign window_in   = {window_ff[2:0], column_bits};

   always_comb begin
      if (reset || geometry_write) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (at_row_end) begin
            col_in = '0;
            row_in = at_last_row ? '0 : row_ff + 8'd1;
         end else begin
            col_in = col_ff + 8'd1;
            row_in = row_ff;
         end
      end else begin
         col_in = col_ff;
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || geometry_write) begin
         col_ff    <= '0;
         row_ff    <= '0;
         window_ff <= '0;
      end else if (accept) begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         window_ff <= window_in;
      end
   end

   // Read the column that the next cell will need, so its data is ready in time;
   // write back the shifted column pair for the current cell.
   cas_ram #(
      .WIDTH (cas_pkg::LINE_DATA_W),
      .DEPTH (cas_pkg::MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (cas_pkg::LINE_ADDR_W'(col_ff)),
      .wr_data ({req_cell_in, line_rd[1]}),
      .rd_addr (cas_pkg::LINE_ADDR_W'(col_in)),
      .rd_data (line_rd)
   );

   // ---------------------------------------------------------------
   // Rule and result selection
   // ---------------------------------------------------------------
   logic [7:0]                  neighbours;
   logic [cas_pkg::COUNT_W-1:0] alive_count;
   logic                        center;
   logic                        interior_val;
   cas_pkg::result_type         raw [cas_pkg::MAX_RESULTS];
   logic [cas_pkg::MAX_RESULTS-1:0] raw_valid;
   cas_pkg::result_type         packed_res [cas_pkg::QUEUE_DEPTH];
   logic [1:0]                  n_results;

   assign center     = window_ff[1];
   assign neighbours = {column_bits, window_ff[5:3], window_ff[2], window_ff[0]};

   always_comb begin
      alive_count = '0;
      for (int i = 0; i < 8; i++) begin
         alive_count = alive_count + cas_pkg::COUNT_W'(neighbours[i]);
      end
   end

   always_comb begin
      // border of the frame stays rock
      if ((row_ff == 8'd1) || (col_ff == 8'd1)) begin
         interior_val = 1'b1;
      end else if (center) begin
         interior_val = !(alive_count < death_limit_ff);
      end else begin
         interior_val = (alive_count > birth_limit_ff);
      end
   end

   always_comb begin
      // cell one row up and one column left
      raw_valid[0]  = (row_ff != '0) && (col_ff != '0);
      raw[0].live   = interior_val;
      raw[0].column = col_ff - 8'd1;
      raw[0].row    = row_ff - 8'd1;
      raw[0].last   = 1'b0;
      // right border of the row above
      raw_valid[1]  = (row_ff != '0) && at_row_end;
      raw[1].live   = 1'b1;
      raw[1].column = width_last;
      raw[1].row    = row_ff - 8'd1;
      raw[1].last   = 1'b0;
      // bottom border, emitted as the last row streams in
      raw_valid[2]  = at_last_row;
      raw[2].live   = 1'b1;
      raw[2].column = col_ff;
      raw[2].row    = row_ff;
      raw[2].last   = at_row_end;
   end

   // compact the valid results into consecutive slots
   always_comb begin
      for (int k = 0; k < cas_pkg::QUEUE_DEPTH; k++) begin
         packed_res[k] = '0;
      end
      n_results = '0;
      for (int i = 0; i < cas_pkg::MAX_RESULTS; i++) begin
         if (raw_valid[i]) begin
            packed_res[n_results] = raw[i];
            n_results = n_results + 2'd1;
         end
      end
   end

   // ---------------------------------------------------------------
   // Result queue
   // ---------------------------------------------------------------
   cas_pkg::result_type               queue_ff [cas_pkg::QUEUE_DEPTH];
   logic [cas_pkg::QUEUE_PTR_W-1:0]   head_ff, head_in;
   logic [cas_pkg::QUEUE_PTR_W-1:0]   tail_ff, tail_in;
   logic [cas_pkg::QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic [1:0]                        push_n;
   logic                              pop;
   logic [cas_pkg::QUEUE_PTR_W-1:0]   slot_off [cas_pkg::QUEUE_DEPTH];
   logic [cas_pkg::QUEUE_DEPTH-1:0]   slot_we;
   cas_pkg::result_type               head_res;

   assign push_n    = accept ? n_results : 2'd0;
   assign pop       = rsp_valid && rsp_ready;
   assign head_in   = head_ff + cas_pkg::QUEUE_PTR_W'(pop);
   assign tail_in   = tail_ff + cas_pkg::QUEUE_PTR_W'(push_n);
   assign count_in  = count_ff + cas_pkg::QUEUE_CNT_W'(push_n) - cas_pkg::QUEUE_CNT_W'(pop);
   // room for a worst-case cell must be there before it is taken
   assign req_ready = (count_ff <= cas_pkg::QUEUE_CNT_W'(cas_pkg::QUEUE_DEPTH -
                                                        cas_pkg::MAX_RESULTS));

   always_comb begin
      for (int s = 0; s < cas_pkg::QUEUE_DEPTH; s++) begin
         slot_off[s] = cas_pkg::QUEUE_PTR_W'(s) - tail_ff;
         slot_we[s]  = accept && (slot_off[s] < n_results);
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < cas_pkg::QUEUE_DEPTH; s++) begin
         if (slot_we[s]) begin
            queue_ff[s] <= packed_res[slot_off[s]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   assign head_res          = queue_ff[head_ff];
   assign rsp_valid         = (count_ff != '0);
   assign rsp_cell_out      = head_res.live;
   assign rsp_out_column    = head_res.column;
   assign rsp_out_row       = head_res.row;
   assign rsp_last_of_frame = head_res.last;

`ifndef SYNTH
   // queue never holds more than its depth
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cas_pkg::QUEUE_CNT_W'(cas_pkg::QUEUE_DEPTH))
      else $error("result queue overfilled");

   // position counters stay inside the frame in use
   a_position: assert property (@(posedge clock) disable iff (reset)
      (col_ff <= width_last) && (row_ff <= height_last))
      else $error("position counter outside the frame");

   // end-of-frame marker only on the bottom-right border cell
   a_last_cell: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_of_frame) |->
         (rsp_cell_out && (rsp_out_column == width_last) && (rsp_out_row == height_last)))
      else $error("last_of_frame on a wrong cell");

   // draining the only result with nothing pushed empties the queue
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (pop && (push_n == 2'd0) && (count_ff == 3'd1)) |=> !rsp_valid)
      else $error("result queue did not drain");
`endif

endmodule

`default_nettype wire
